@@ src/hec_pkg.sv @@
package hec_pkg;

  localparam int CODE_BITS = 63;
  localparam int SYN_BITS  = 6;
  localparam int LEN_BITS  = 6;

  // Operation codes
  localparam logic OP_ENCODE  = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CORRECTED = 2'd1;
  localparam logic [1:0] STATUS_BEYOND    = 2'd2;

  // Register index (address bit 2)
  localparam logic REG_DATA_LENGTH = 1'b0;

  typedef struct packed {
    logic                 op;
    logic [CODE_BITS-1:0] word;
  } request_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] result_word;
    logic [SYN_BITS-1:0]  syndrome;
    logic [1:0]           status;
  } result_t;

  // Codeword length for k data bits: k plus smallest r with 2^r >= k+r+1
  function automatic logic [6:0] code_length(input logic [LEN_BITS-1:0] k);
    logic [3:0] r;
    logic       done;
    r    = 4'd0;
    done = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (!done) begin
        if ((8'd1 << r) < (8'(r) + 8'(k) + 8'd1)) begin
          r = r + 4'd1;
        end else begin
          done = 1'b1;
        end
      end
    end
    return 7'(r) + 7'(k);
  endfunction

  // Largest data length whose codeword fits in max_bits
  function automatic logic [LEN_BITS-1:0] max_data_bits(input int max_bits);
    logic [LEN_BITS-1:0] best;
    best = LEN_BITS'(1);
    for (int k = 1; k < 64; k++) begin
      if (int'(code_length(LEN_BITS'(k))) <= max_bits) begin
        best = LEN_BITS'(k);
      end
    end
    return best;
  endfunction

  // Scatter data bits onto the positions that are not powers of two
  function automatic logic [CODE_BITS-1:0] spread_data(input logic [CODE_BITS-1:0] data);
    logic [CODE_BITS-1:0] cw;
    int                   d;
    cw = '0;
    d  = 0;
    for (int pos = 1; pos <= CODE_BITS; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        cw[pos-1] = data[d];
        d++;
      end
    end
    return cw;
  endfunction

  // XOR of the positions holding a one
  function automatic logic [SYN_BITS-1:0] syndrome_of(input logic [CODE_BITS-1:0] cw);
    logic [SYN_BITS-1:0] s;
    s = '0;
    for (int j = 0; j < SYN_BITS; j++) begin
      for (int pos = 1; pos <= CODE_BITS; pos++) begin
        if (((pos >> j) & 1) != 0) begin
          s[j] = s[j] ^ cw[pos-1];
        end
      end
    end
    return s;
  endfunction

endpackage

@@ src/hamming_encode_and_correct_top.sv @@
// Hamming single-error-correcting encoder and corrector.
//
// Request channel (request_valid / request_stall / request): op selects
// encode (data bits in word) or check-and-correct (codeword, position i+1
// at bit i). Result channel (result_valid / result_stall / result) returns
// one result per request: codeword, syndrome and status.
// The data length register sits at byte address 0 of the APB port; the user
// must write it only while no request is in flight; the block does not enforce it.
// An accepted request passes three register stages on the way to result_valid:
// spread and mask, syndrome XOR tree, then parity insertion or single-bit flip.
// Throughput is one request per cycle while the receiver does not stall; every
// stage advances on its own, so bubbles close up.
// When the receiver stalls, the result register holds and the stages behind
// it fill; request_stall rises only once all three stages hold requests.
// Reset (rst, synchronous) empties the pipeline and sets the data length
// to four.
module hamming_encode_and_correct_top #(
  parameter int MAX_CODE_BITS = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  hec_pkg::request_t   request,
  output logic                result_valid,
  input  logic                result_stall,
  output hec_pkg::result_t    result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hec_pkg::*;

  localparam logic [LEN_BITS-1:0] K_MAX   = max_data_bits(MAX_CODE_BITS);
  localparam logic [LEN_BITS-1:0] K_RESET = (LEN_BITS'(4) > K_MAX) ? K_MAX : LEN_BITS'(4);
  localparam logic [SYN_BITS-1:0] N_RESET = SYN_BITS'(code_length(K_RESET));

  // Configuration registers
  logic [LEN_BITS-1:0]  data_length;
  logic [SYN_BITS-1:0]  code_len;
  logic [CODE_BITS-1:0] code_mask;

  logic [LEN_BITS-1:0]  k_next;
  logic [SYN_BITS-1:0]  n_next;
  logic [CODE_BITS-1:0] mask_next;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DATA_LENGTH);

  // Effective length: zero acts as one, long values clamp to what fits
  always_comb begin
    k_next = pwdata[LEN_BITS-1:0];
    if (k_next == '0) begin
      k_next = LEN_BITS'(1);
    end
    if (k_next > K_MAX) begin
      k_next = K_MAX;
    end
    n_next = SYN_BITS'(code_length(k_next));
    for (int i = 0; i < CODE_BITS; i++) begin
      mask_next[i] = (7'(i) < 7'(n_next));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_length <= LEN_BITS'(4);
      code_len    <= N_RESET;
      for (int i = 0; i < CODE_BITS; i++) begin
        code_mask[i] <= (7'(i) < 7'(N_RESET));
      end
    end else if (cfg_write) begin
      data_length <= pwdata[LEN_BITS-1:0];
      code_len    <= n_next;
      code_mask   <= mask_next;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DATA_LENGTH) begin
      prdata = 32'(data_length);
    end
  end

  // Pipeline flow control
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3          = !v3 || !result_stall;
  assign adv2          = !v2 || adv3;
  assign adv1          = !v1 || adv2;
  assign request_stall = !adv1;
  assign result_valid  = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= request_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1: place data bits or take the codeword, mask to length
  logic                 s1_op;
  logic [CODE_BITS-1:0] s1_cw;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op <= request.op;
      if (request.op == OP_ENCODE) begin
        s1_cw <= spread_data(request.word) & code_mask;
      end else begin
        s1_cw <= request.word & code_mask;
      end
    end
  end

  // Stage 2: syndrome tree
  logic                 s2_op;
  logic [CODE_BITS-1:0] s2_cw;
  logic [SYN_BITS-1:0]  s2_syn;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_op  <= s1_op;
      s2_cw  <= s1_cw;
      s2_syn <= syndrome_of(s1_cw);
    end
  end

  // Stage 3: insert parity bits, or flip the bit the syndrome names
  result_t              res_next;
  logic [CODE_BITS-1:0] flip;
  logic [CODE_BITS-1:0] parity;

  always_comb begin
    for (int i = 0; i < CODE_BITS; i++) begin
      flip[i]   = (s2_syn == SYN_BITS'(i + 1));
      parity[i] = 1'b0;
    end
    for (int j = 0; j < SYN_BITS; j++) begin
      parity[(1 << j) - 1] = s2_syn[j];
    end
    res_next = '0;
    unique case (s2_op)
      OP_ENCODE: begin
        res_next.result_word = (s2_cw | parity) & code_mask;
        res_next.syndrome    = '0;
        res_next.status      = STATUS_OK;
      end
      OP_CORRECT: begin
        res_next.syndrome = s2_syn;
        if (s2_syn == '0) begin
          res_next.result_word = s2_cw;
          res_next.status      = STATUS_OK;
        end else if (s2_syn <= code_len) begin
          res_next.result_word = s2_cw ^ flip;
          res_next.status      = STATUS_CORRECTED;
        end else begin
          res_next.result_word = s2_cw;
          res_next.status      = STATUS_BEYOND;
        end
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      result <= res_next;
    end
  end

  // Checks
  a_word_in_length: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.result_word & ~code_mask) == '0))
    else $error("result bits beyond codeword length");

  a_corrected_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == STATUS_CORRECTED))
      |-> ((result.syndrome != '0) && (result.syndrome <= code_len)))
    else $error("correction with syndrome out of range");

  a_zero_syndrome_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.syndrome == '0)) |-> (result.status == STATUS_OK))
    else $error("zero syndrome with error status");

endmodule

@@ tb/hamming_encode_and_correct_top_tb.sv @@
`timescale 1ns / 100ps

module hamming_encode_and_correct_top_tb;
  import hec_pkg::*;

  localparam int          IDLE_PCT         = 16;
  localparam int          PIPE_DEPTH       = 3;
  localparam int          HOLD_CYCLES      = 60;
  localparam int          STALL_LIMIT      = 2000;
  localparam int          PHASES           = 12;
  localparam int          ITEMS_PER_PHASE  = 104;
  localparam int          MAX_CODE         = 63;
  localparam logic [2:0]  LENGTH_ADDR      = {REG_DATA_LENGTH, 2'b00};
  localparam logic [2:0]  UNUSED_ADDR      = {~REG_DATA_LENGTH, 2'b00};

  logic                 clk;
  logic                 rst;
  logic                 request_valid;
  logic                 request_stall;
  request_t             request;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // predictor copy of the length register
  logic [LEN_BITS-1:0]  data_length_now;
  result_t              pending_results[$];
  result_t              oldest;

  // run control
  bit                   sender_gaps;
  bit                   sink_gaps;
  bit                   long_hold_req;
  int                   hold_left;
  int                   quiet_cycles;

  // bookkeeping
  int                   mismatches;
  int                   unexpected_results;
  int                   checked_results;
  int                   encodes_seen;
  int                   clean_checks;
  int                   repairs_seen;
  int                   beyond_seen;
  int                   lengths_used;
  int                   input_stall_cycles;

  hamming_encode_and_correct_top dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- predictor

  // codeword length for k data bits
  function automatic int unsigned codeword_bits(input int unsigned k);
    int unsigned r;
    r = 0;
    while (r < 7 && (1 << r) < r + k + 1) r++;
    return r + k;
  endfunction

  // length the block actually uses for a given register value
  function automatic int unsigned active_code_bits(input logic [LEN_BITS-1:0] len);
    int unsigned k;
    int unsigned n;
    k = len;
    if (k < 1) k = 1;
    while (k > 1 && codeword_bits(k) > MAX_CODE) k--;
    n = codeword_bits(k);
    if (n > 63) n = 63;
    return n;
  endfunction

  function automatic logic [CODE_BITS-1:0] code_mask(input int unsigned n);
    return (n >= 63) ? '1 : ((63'd1 << n) - 63'd1);
  endfunction

  // XOR of the numbers of set positions, positions 1..n
  function automatic logic [SYN_BITS-1:0] position_xor(input logic [CODE_BITS-1:0] cw,
                                                       input int unsigned n);
    logic [SYN_BITS-1:0] s;
    int unsigned         pos;
    s = '0;
    for (pos = 1; pos <= n; pos++) begin
      if (cw[pos-1]) s = s ^ SYN_BITS'(pos);
    end
    return s;
  endfunction

  function automatic result_t hamming_predict(input request_t req,
                                              input logic [LEN_BITS-1:0] len);
    int unsigned          n;
    int unsigned          d;
    int unsigned          pos;
    int unsigned          j;
    int unsigned          syn;
    logic [SYN_BITS-1:0]  parity;
    logic [CODE_BITS-1:0] mask;
    logic [CODE_BITS-1:0] cw;
    result_t              res;
    n    = active_code_bits(len);
    mask = code_mask(n);
    cw   = '0;
    syn  = 0;
    res.status = STATUS_OK;
    if (req.op == OP_ENCODE) begin
      // data onto non-power-of-two positions, then parity bits
      d = 0;
      for (pos = 1; pos <= n; pos++) begin
        if ((pos & (pos - 1)) != 0) begin
          cw[pos-1] = req.word[d];
          d++;
        end
      end
      parity = position_xor(cw, n);
      for (j = 0; j < SYN_BITS && (1 << j) <= n; j++) begin
        if (parity[j]) cw[(1 << j) - 1] = 1'b1;
      end
    end else begin
      cw  = req.word & mask;
      syn = position_xor(cw, n);
      if (syn == 0) begin
        res.status = STATUS_OK;
      end else if (syn <= n) begin
        cw[syn-1]  = ~cw[syn-1];
        res.status = STATUS_CORRECTED;
      end else begin
        res.status = STATUS_BEYOND;
      end
    end
    res.result_word = cw & mask;
    res.syndrome    = SYN_BITS'(syn);
    return res;
  endfunction

  function automatic logic [CODE_BITS-1:0] encode_now(input logic [CODE_BITS-1:0] data);
    request_t req;
    result_t  res;
    req.op   = OP_ENCODE;
    req.word = data;
    res      = hamming_predict(req, data_length_now);
    return res.result_word;
  endfunction

  function automatic logic [CODE_BITS-1:0] random_word();
    return CODE_BITS'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_request(input logic op, input logic [CODE_BITS-1:0] word);
    request_t req;
    req.op   = op;
    req.word = word;
    @(negedge clk);
    while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
      request_valid <= 1'b0;
      @(negedge clk);
    end
    request_valid <= 1'b1;
    request       <= req;
    @(posedge clk);
    while (request_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    pending_results.push_back(hamming_predict(req, data_length_now));
  endtask

  // drop valid and let the pipeline empty before touching the register
  task automatic finish_phase();
    @(negedge clk);
    request_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", field, want, got);
  endtask

  // write, then read back where the address holds the register
  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == LENGTH_ADDR) begin
      data_length_now = value[LEN_BITS-1:0];
      lengths_used++;
    end
    @(negedge clk);
    if (addr == LENGTH_ADDR) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata !== 32'(data_length_now))
        report_mismatch("data_length readback", 64'(data_length_now), 64'(prdata));
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random encodes, valid codewords with zero or one error, and some pure noise
  task automatic send_random_item();
    int unsigned          n;
    int unsigned          pick;
    int unsigned          pos;
    logic [CODE_BITS-1:0] cw;
    n    = active_code_bits(data_length_now);
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_request(OP_ENCODE, random_word());
    end else if (pick < 85) begin
      cw = encode_now(random_word());
      if (pick >= 50) begin
        pos       = $urandom_range(n, 1);
        cw[pos-1] = ~cw[pos-1];
      end
      if ($urandom_range(1) != 0) cw = cw | (random_word() & ~code_mask(n));
      send_request(OP_CORRECT, cw);
    end else begin
      send_request(OP_CORRECT, random_word());
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    result_stall = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= sink_gaps && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        unexpected_results++;
        if (unexpected_results <= 10)
          $display("result with nothing outstanding: word %h syndrome %h status %h",
                   result.result_word, result.syndrome, result.status);
      end else begin
        oldest = pending_results.pop_front();
        checked_results++;
        if (result.result_word !== oldest.result_word)
          report_mismatch("result_word", 64'(oldest.result_word), 64'(result.result_word));
        if (result.syndrome !== oldest.syndrome)
          report_mismatch("syndrome", 64'(oldest.syndrome), 64'(result.syndrome));
        if (result.status !== oldest.status)
          report_mismatch("status", 64'(oldest.status), 64'(result.status));
        case (oldest.status)
          STATUS_CORRECTED: repairs_seen++;
          STATUS_BEYOND:    beyond_seen++;
          default:          if (oldest.syndrome == '0 && result.syndrome == '0) clean_checks++;
        endcase
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset length of four data bits, seven-bit codewords
  task automatic test_reset_length();
    logic [CODE_BITS-1:0] cw;
    send_request(OP_ENCODE, '0);
    send_request(OP_ENCODE, '1);
    send_request(OP_CORRECT, '0);
    send_request(OP_CORRECT, '1);
    cw    = encode_now(63'hB);
    cw[4] = ~cw[4];
    send_request(OP_CORRECT, cw);
    encodes_seen += 2;
  endtask

  // unused register address, zero length, syndrome past the codeword end
  task automatic test_short_codes();
    finish_phase();
    write_register(UNUSED_ADDR, 32'd9);
    send_request(OP_ENCODE, {{(CODE_BITS-4){1'b1}}, 4'b0000});
    finish_phase();
    write_register(LENGTH_ADDR, 32'd0);
    send_request(OP_ENCODE, 63'd1);
    send_request(OP_CORRECT, {random_word()} << 3 | 63'b100);
    finish_phase();
    write_register(LENGTH_ADDR, 32'd2);
    send_request(OP_CORRECT, 63'b01010);
    send_request(OP_CORRECT, '1);
    encodes_seen += 2;
  endtask

  // longest codes, including a length beyond what fits
  task automatic test_long_codes();
    logic [CODE_BITS-1:0] cw;
    finish_phase();
    write_register(LENGTH_ADDR, 32'd57);
    send_request(OP_ENCODE, '1);
    send_request(OP_CORRECT, '1);
    cw     = encode_now(random_word());
    cw[62] = ~cw[62];
    send_request(OP_CORRECT, cw);
    cw[62] = ~cw[62];
    cw[0]  = ~cw[0];
    send_request(OP_CORRECT, cw);
    finish_phase();
    write_register(LENGTH_ADDR, {26'h3FFFFFF, 6'd63});
    send_request(OP_ENCODE, '1);
    cw     = encode_now('1);
    cw[31] = ~cw[31];
    send_request(OP_CORRECT, cw);
    encodes_seen += 2;
  endtask

  function automatic logic [LEN_BITS-1:0] phase_length(input int p);
    case (p)
      0:       return 6'd1;
      1:       return 6'd2;
      2:       return 6'd3;
      3:       return 6'd4;
      4:       return 6'd0;
      5:       return 6'd11;
      6:       return 6'd26;
      7:       return 6'd57;
      8:       return 6'd63;
      9:       return 6'd5;
      default: return LEN_BITS'($urandom_range(63));
    endcase
  endfunction

  // random traffic over a range of lengths, with one phase free of gaps
  task automatic test_random_traffic();
    int p;
    int i;
    for (p = 0; p < PHASES; p++) begin
      finish_phase();
      write_register(LENGTH_ADDR, {26'($urandom), phase_length(p)});
      sender_gaps = (p != 4);
      sink_gaps   = (p != 4);
      if (p == 2 || p == 7) long_hold_req = 1'b1;
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
    end
    sender_gaps = 1'b1;
    sink_gaps   = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                = 1'b1;
    request_valid      = 1'b0;
    request            = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    data_length_now    = 6'd4;
    sender_gaps        = 1'b1;
    sink_gaps          = 1'b1;
    long_hold_req      = 1'b0;
    quiet_cycles       = 0;
    mismatches         = 0;
    unexpected_results = 0;
    checked_results    = 0;
    encodes_seen       = 0;
    clean_checks       = 0;
    repairs_seen       = 0;
    beyond_seen        = 0;
    lengths_used       = 1;
    input_stall_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_length();
    test_short_codes();
    test_long_codes();
    test_random_traffic();

    finish_phase();
    repeat (PIPE_DEPTH + 5) @(posedge clk);

    $display("checked %0d results across %0d length settings: %0d repairs, %0d past end",
             checked_results, lengths_used, repairs_seen, beyond_seen);
    $display("zero-syndrome results %0d, input held back for %0d cycles",
             clean_checks, input_stall_cycles);
    if (mismatches + unexpected_results + pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("mismatches %0d, unexpected %0d, missing %0d",
               mismatches, unexpected_results, pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
